>>> src/lkvc_pkg.sv
// lkvc_pkg: shared constants and types for the lru key/value cache
// no dependencies
`timescale 1ns / 1ps
package lkvc_pkg;
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned IdxBits    = $clog2(MaxEntries);
  localparam int unsigned CntBits    = $clog2(MaxEntries + 1);
  localparam int unsigned CapBits    = 5;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  // operation word entering the cache
  typedef struct packed {
    logic                        operation;
    logic signed [KeyBits-1:0]   key;
    logic signed [ValueBits-1:0] value;
  } req_t;

  // result word
  typedef struct packed {
    logic                        found;
    logic signed [ValueBits-1:0] read_value;
    logic                        evicted;
  } rsp_t;
endpackage

>>> src/lkvc_req_if.sv
// lkvc_req_if: valid/ready channel carrying an operation word
// depends on lkvc_pkg
`timescale 1ns / 1ps
interface lkvc_req_if;
  logic valid;
  logic ready;
  lkvc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/lkvc_rsp_if.sv
// lkvc_rsp_if: valid/ready channel carrying a result word
// depends on lkvc_pkg
`timescale 1ns / 1ps
interface lkvc_rsp_if;
  logic valid;
  logic ready;
  lkvc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/lkvc_ram.sv
// lkvc_ram: generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
module lkvc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/lkvc_tags.sv
// lkvc_tags: per-entry keys, valid bits and age ranks; parallel match and victim pick
// depends on lkvc_pkg
`timescale 1ns / 1ps
module lkvc_tags (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic [lkvc_pkg::KeyBits-1:0] key_i,
  input  lkvc_pkg::cnt_t               cap_i,
  output logic                         hit_o,
  output logic                         full_o,
  output lkvc_pkg::idx_t               slot_o,
  output logic                         slot_ok_o,
  input  logic                         upd_i,
  input  logic                         ins_i,
  input  lkvc_pkg::idx_t               upd_slot_i
);
  import lkvc_pkg::*;

  logic [KeyBits-1:0] key_q [MaxEntries];
  logic [MaxEntries-1:0] valid_q;
  idx_t age_q [MaxEntries];
  cnt_t count_q;

  logic [MaxEntries-1:0] match, free, lru;
  idx_t hit_idx, free_idx, lru_idx;
  logic any_free, any_lru;

  // parallel compare and priority picks
  always_comb begin
    hit_idx = '0; free_idx = '0; lru_idx = '0;
    hit_o = 1'b0; any_free = 1'b0; any_lru = 1'b0;
    for (int i = 0; i < MaxEntries; i++) begin
      match[i] = valid_q[i] && (key_q[i] == key_i);
      free[i]  = !valid_q[i];
      lru[i]   = valid_q[i] && ({1'b0, age_q[i]} + cnt_t'(1) == count_q);
    end
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (match[i]) begin hit_o = 1'b1; hit_idx = idx_t'(i); end
      if (free[i]) begin any_free = 1'b1; free_idx = idx_t'(i); end
      if (lru[i]) begin any_lru = 1'b1; lru_idx = idx_t'(i); end
    end
  end

  assign full_o    = !(count_q < cap_i);
  assign slot_o    = hit_o ? hit_idx : (full_o ? lru_idx : free_idx);
  assign slot_ok_o = hit_o || (full_o ? any_lru : any_free);

  // recency update: promote hit or fresh insert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MaxEntries; i++) age_q[i] <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MaxEntries; i++) age_q[i] <= '0;
    end else if (upd_i || ins_i) begin
      for (int i = 0; i < MaxEntries; i++) begin
        if (idx_t'(i) == upd_slot_i) begin
          age_q[i] <= '0;
        end else if (valid_q[i] && (ins_i || age_q[i] < age_q[upd_slot_i])) begin
          age_q[i] <= age_q[i] + idx_t'(1);
        end
      end
      if (ins_i) begin
        valid_q[upd_slot_i] <= 1'b1;
        if (!full_o) count_q <= count_q + cnt_t'(1);
      end
    end
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (ins_i) key_q[upd_slot_i] <= key_i;
  end
endmodule

>>> src/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key/value cache with lru replacement
// one operation at a time: a new word is taken only after the last result is handed off
// (lookup with value ram read, then write-back, then result handoff), plus any output stall
// reset (async, rst_ni low) empties the cache and sets capacity to 16
// writing capacity empties the cache, taking effect in the cycle after the write
`timescale 1ns / 1ps
module lru_key_value_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CapBits-1:0]  cfg_wdata_i,
  lkvc_req_if.sink                      req,
  lkvc_rsp_if.source                    rsp
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {StIdle, StRead, StOut} state_e;
  state_e state_q;
  req_t   req_q;
  cnt_t   cap_q;
  rsp_t   rsp_q;
  idx_t   slot_q;
  logic   hit_q, ok_q, full_q;

  logic hit, full, slot_ok, upd, ins;
  idx_t slot;
  logic [ValueBits-1:0] rdata;
  logic [KeyBits-1:0] look_key;
  cnt_t cap_d;

  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StOut);
  assign rsp.data  = rsp_q;

  // capacity clamp
  always_comb begin
    if (cfg_wdata_i == '0) cap_d = cnt_t'(1);
    else if (cfg_wdata_i > CapBits'(MaxEntries)) cap_d = cnt_t'(MaxEntries);
    else cap_d = cnt_t'(cfg_wdata_i);
  end

  // lookup on the incoming word while idle, store the held key on insert
  assign look_key = (state_q == StIdle) ? req.data.key : req_q.key;

  lkvc_tags u_tags (
    .clk_i, .rst_ni,
    .clear_i   (cfg_we_i),
    .key_i     (look_key),
    .cap_i     (cap_q),
    .hit_o     (hit),
    .full_o    (full),
    .slot_o    (slot),
    .slot_ok_o (slot_ok),
    .upd_i     (upd),
    .ins_i     (ins),
    .upd_slot_i(slot_q)
  );

  // the read state commits the recency change
  assign upd = (state_q == StRead) && hit_q;
  assign ins = (state_q == StRead) && !hit_q && req_q.operation == OpPut && ok_q;

  lkvc_ram #(.Width(ValueBits), .Depth(MaxEntries)) u_values (
    .clk_i,
    .we_i   ((state_q == StRead) && req_q.operation == OpPut && (hit_q || ok_q)),
    .waddr_i(slot_q),
    .wdata_i(req_q.value),
    .raddr_i(slot),
    .rdata_o(rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= cnt_t'(MaxEntries);
    end else begin
      if (cfg_we_i) cap_q <= cap_d;
      case (state_q)
        StIdle: if (req.valid) begin
          req_q   <= req.data;
          state_q <= StRead;
        end
        StRead: begin
          rsp_q.found      <= hit_q;
          rsp_q.read_value <= (req_q.operation == OpPut) ? '0 : (hit_q ? rdata : '1);
          rsp_q.evicted    <= (req_q.operation == OpPut) && !hit_q && full_q && ok_q;
          state_q          <= StOut;
        end
        StOut: if (rsp.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // lookup results captured with the ram read
  always_ff @(posedge clk_i) begin
    slot_q <= slot;
    hit_q  <= hit;
    ok_q   <= slot_ok;
    full_q <= full;
  end
endmodule
